// ===== hdl/rtc_pkg.sv =====
package rtc_pkg;

    localparam int VALUE_W = 47;
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_SET      = 3'd1,
        OP_GET      = 3'd2,
        OP_ALARM    = 3'd3,
        OP_ROLLOVER = 3'd4
    } rtc_op_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] value;
        logic               in_ticks;
        logic               enable;
    } rtc_item_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] read_value;
        logic               alarm_event;
        logic               rollover_event;
    } rtc_result_t;

endpackage

// ===== hdl/rtc_core.sv =====
module rtc_core import rtc_pkg::*; #(
    parameter int FRACTION_BITS = 15,
    parameter int SECONDS_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  rtc_item_t   item,
    output rtc_result_t result
);

    localparam int TICK_BITS = FRACTION_BITS + SECONDS_BITS;
    localparam int WIDE_W = (TICK_BITS > VALUE_W) ? TICK_BITS : VALUE_W;
    localparam logic [TICK_BITS:0] ONE_SECOND = (TICK_BITS+1)'(1) << FRACTION_BITS;
    localparam logic [TICK_BITS:0] TOP_TICKS =
        {1'b0, {SECONDS_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};

    logic [TICK_BITS-1:0] tick_count_reg, tick_count_next;
    logic [TICK_BITS-1:0] alarm_ticks_reg, alarm_ticks_next;
    logic                 alarm_armed_reg, alarm_armed_next;
    logic                 rollover_armed_reg, rollover_armed_next;

    logic [WIDE_W-1:0]    value_wide;
    logic [WIDE_W-1:0]    count_wide;
    logic [TICK_BITS-1:0] value_ticks;
    logic [TICK_BITS-1:0] value_secs;
    logic [TICK_BITS:0]   sum;
    logic                 wrap;
    logic [TICK_BITS-1:0] ticked;

    assign value_wide  = WIDE_W'(item.value);
    assign count_wide  = WIDE_W'(tick_count_reg);
    assign value_ticks = value_wide[TICK_BITS-1:0];
    assign value_secs  = {item.value[SECONDS_BITS-1:0], {FRACTION_BITS{1'b0}}};
    assign sum         = {1'b0, tick_count_reg} + ONE_SECOND;
    assign wrap        = sum > TOP_TICKS;
    assign ticked      = wrap ? '0 : sum[TICK_BITS-1:0];

    always_comb begin
        tick_count_next     = tick_count_reg;
        alarm_ticks_next    = alarm_ticks_reg;
        alarm_armed_next    = alarm_armed_reg;
        rollover_armed_next = rollover_armed_reg;
        result              = '0;
        case (rtc_op_t'(item.operation))
            OP_TICK: begin
                tick_count_next = ticked;
                if (wrap && rollover_armed_reg) begin
                    rollover_armed_next   = 1'b0;
                    result.rollover_event = 1'b1;
                end
                result.alarm_event = alarm_armed_reg && (ticked >= alarm_ticks_reg);
            end
            OP_SET: begin
                tick_count_next = item.in_ticks ? value_ticks : value_secs;
            end
            OP_GET: begin
                if (item.in_ticks) begin
                    result.read_value = count_wide[VALUE_W-1:0];
                end else begin
                    result.read_value = VALUE_W'(tick_count_reg[TICK_BITS-1:FRACTION_BITS]);
                end
            end
            OP_ALARM: begin
                if (item.enable) begin
                    if (value_secs <= tick_count_reg) begin
                        result.status = 1'b1;
                    end else begin
                        alarm_ticks_next = value_secs;
                        alarm_armed_next = 1'b1;
                    end
                end else begin
                    alarm_armed_next = 1'b0;
                end
            end
            OP_ROLLOVER: begin
                rollover_armed_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg     <= '0;
            alarm_ticks_reg    <= '0;
            alarm_armed_reg    <= 1'b0;
            rollover_armed_reg <= 1'b0;
        end else if (fire) begin
            tick_count_reg     <= tick_count_next;
            alarm_ticks_reg    <= alarm_ticks_next;
            alarm_armed_reg    <= alarm_armed_next;
            rollover_armed_reg <= rollover_armed_next;
        end
    end

endmodule

// ===== hdl/rtc_with_alarm_and_rollover.sv =====
// Real-time clock that counts in sub-second ticks, with an alarm and a rollover event.
// The input channel (s_valid, s_ready) carries one operation per transfer: tick,
// set time, get time, set or clear the alarm, or arm the rollover event.
// The result channel (m_valid, m_ready) returns exactly one result per operation,
// in order: a status, the time read by a get, and the alarm and rollover events of a tick.
// An operation is captured in an input register, processed combinationally
// against the clock state, and its result lands in an output register.
// Throughput is one operation per cycle while the receiver does not stall; the
// combinational add and compare on the tick count set that figure.
// Reset clears the time, the alarm time and both arm flags, and empties both registers.
// When the receiver stalls, the output register holds its result and the input
// register takes one more operation; s_ready then drops until the result is taken.
module rtc_with_alarm_and_rollover import rtc_pkg::*; #(
    parameter int FRACTION_BITS = 15,
    parameter int SECONDS_BITS  = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               s_in_ticks,
    input  logic               s_enable,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [VALUE_W-1:0] m_read_value,
    output logic               m_alarm_event,
    output logic               m_rollover_event
);

    logic        in_valid_reg;
    rtc_item_t   item_reg;
    logic        out_valid_reg;
    rtc_result_t result_reg;
    rtc_result_t result_next;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rtc_core #(
        .FRACTION_BITS(FRACTION_BITS),
        .SECONDS_BITS (SECONDS_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (advance),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= '{operation: s_operation, value: s_value,
                          in_ticks: s_in_ticks, enable: s_enable};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = result_reg.status;
    assign m_read_value     = result_reg.read_value;
    assign m_alarm_event    = result_reg.alarm_event;
    assign m_rollover_event = result_reg.rollover_event;

`ifndef SYNTHESIS
    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but s_ready low");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed operation did not reach the output register");

    a_reject_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |->
            (!m_alarm_event && !m_rollover_event && m_read_value == '0))
        else $error("rejected alarm result carries other fields");
`endif

endmodule
